// ===== sv/rnd_pkg.sv =====
`timescale 1ns / 1ps

package rnd_pkg;

    localparam int CODE_W  = 16;
    localparam int POS_W   = 16;
    localparam int TOTAL_W = 16;
    localparam int DIGIT_W = 10;

    // Character codes of the Roman digits, upper and lower case
    localparam logic [CODE_W-1:0] CH_I_UP = 16'h0049;
    localparam logic [CODE_W-1:0] CH_V_UP = 16'h0056;
    localparam logic [CODE_W-1:0] CH_X_UP = 16'h0058;
    localparam logic [CODE_W-1:0] CH_L_UP = 16'h004C;
    localparam logic [CODE_W-1:0] CH_C_UP = 16'h0043;
    localparam logic [CODE_W-1:0] CH_D_UP = 16'h0044;
    localparam logic [CODE_W-1:0] CH_M_UP = 16'h004D;
    localparam logic [CODE_W-1:0] CH_I_LO = 16'h0069;
    localparam logic [CODE_W-1:0] CH_V_LO = 16'h0076;
    localparam logic [CODE_W-1:0] CH_X_LO = 16'h0078;
    localparam logic [CODE_W-1:0] CH_L_LO = 16'h006C;
    localparam logic [CODE_W-1:0] CH_C_LO = 16'h0063;
    localparam logic [CODE_W-1:0] CH_D_LO = 16'h0064;
    localparam logic [CODE_W-1:0] CH_M_LO = 16'h006D;
    localparam logic [CODE_W-1:0] CH_TERM = 16'h0000;

    localparam logic [DIGIT_W-1:0] VAL_I    = 10'd1;
    localparam logic [DIGIT_W-1:0] VAL_V    = 10'd5;
    localparam logic [DIGIT_W-1:0] VAL_X    = 10'd10;
    localparam logic [DIGIT_W-1:0] VAL_L    = 10'd50;
    localparam logic [DIGIT_W-1:0] VAL_C    = 10'd100;
    localparam logic [DIGIT_W-1:0] VAL_D    = 10'd500;
    localparam logic [DIGIT_W-1:0] VAL_M    = 10'd1000;
    localparam logic [DIGIT_W-1:0] VAL_NONE = 10'd0;

    typedef struct packed {
        logic [POS_W-1:0]  start_offset;
        logic [CODE_W-1:0] code;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]   end_position;
        logic [TOTAL_W-1:0] total;
    } result_t;

    // Digit value of a character; zero for anything that is not a Roman digit
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CODE_W-1:0] c);
        logic [DIGIT_W-1:0] v;
        begin
            case (c)
                CH_I_UP, CH_I_LO: v = VAL_I;
                CH_V_UP, CH_V_LO: v = VAL_V;
                CH_X_UP, CH_X_LO: v = VAL_X;
                CH_L_UP, CH_L_LO: v = VAL_L;
                CH_C_UP, CH_C_LO: v = VAL_C;
                CH_D_UP, CH_D_LO: v = VAL_D;
                CH_M_UP, CH_M_LO: v = VAL_M;
                default:          v = VAL_NONE;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== sv/rnd_in_reg.sv =====
`timescale 1ns / 1ps

module rnd_in_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rnd_pkg::item_t in_item,
    output logic          out_valid,
    input  logic          out_take,
    output rnd_pkg::item_t out_item
);

    logic           valid_reg;
    logic           valid_next;
    rnd_pkg::item_t item_reg;

    // Take a new word when empty or when the held one moves on
    assign in_ready  = !valid_reg || out_take;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/rnd_core.sv =====
`timescale 1ns / 1ps

module rnd_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  rnd_pkg::item_t   item,
    output logic             res_valid,
    output rnd_pkg::result_t res
);

    logic [rnd_pkg::DIGIT_W-1:0] held_reg;
    logic [rnd_pkg::DIGIT_W-1:0] held_next;
    logic [rnd_pkg::TOTAL_W-1:0] total_reg;
    logic [rnd_pkg::TOTAL_W-1:0] total_next;
    logic [rnd_pkg::POS_W-1:0]   count_reg;
    logic [rnd_pkg::POS_W-1:0]   count_next;
    logic [rnd_pkg::POS_W-1:0]   base_reg;
    logic [rnd_pkg::POS_W-1:0]   base_next;
    logic                        in_string_reg;
    logic                        in_string_next;
    logic                        skipping_reg;
    logic                        skipping_next;

    logic [rnd_pkg::DIGIT_W-1:0] held_cur;
    logic [rnd_pkg::TOTAL_W-1:0] total_cur;
    logic [rnd_pkg::POS_W-1:0]   count_cur;
    logic [rnd_pkg::POS_W-1:0]   base_cur;
    logic [rnd_pkg::DIGIT_W-1:0] v;
    logic [rnd_pkg::TOTAL_W-1:0] held_ext;
    logic [rnd_pkg::TOTAL_W-1:0] total_upd;
    logic                        is_term;

    assign v        = rnd_pkg::digit_value(item.code);
    assign is_term  = (item.code == rnd_pkg::CH_TERM);
    // Start a fresh string on its first character
    assign held_cur  = in_string_reg ? held_reg  : '0;
    assign total_cur = in_string_reg ? total_reg : '0;
    assign count_cur = in_string_reg ? count_reg : '0;
    assign base_cur  = in_string_reg ? base_reg  : item.start_offset;
    assign held_ext  = {{(rnd_pkg::TOTAL_W-rnd_pkg::DIGIT_W){1'b0}}, held_cur};

    always_comb
    begin
        if (held_cur == '0)
        begin
            total_upd = total_cur;
        end
        else if (held_cur >= v)
        begin
            total_upd = total_cur + held_ext;
        end
        else
        begin
            total_upd = total_cur - held_ext;
        end
    end

    always_comb
    begin
        held_next      = held_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        in_string_next = in_string_reg;
        skipping_next  = skipping_reg;
        res_valid      = 1'b0;
        res.total        = total_upd;
        res.end_position = base_cur + count_cur - 1'b1;
        if (fire)
        begin
            if (skipping_reg)
            begin
                if (is_term)
                begin
                    skipping_next  = 1'b0;
                    in_string_next = 1'b0;
                end
            end
            else if (v != rnd_pkg::VAL_NONE)
            begin
                held_next      = v;
                total_next     = total_upd;
                count_next     = count_cur + 1'b1;
                base_next      = base_cur;
                in_string_next = 1'b1;
            end
            else
            begin
                res_valid      = 1'b1;
                held_next      = '0;
                total_next     = total_upd;
                count_next     = count_cur;
                base_next      = base_cur;
                in_string_next = !is_term;
                skipping_next  = !is_term;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            base_reg      <= '0;
            in_string_reg <= 1'b0;
            skipping_reg  <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            in_string_reg <= in_string_next;
            skipping_reg  <= skipping_next;
        end
    end

endmodule

// ===== sv/roman_numeral_decoder.sv =====
`timescale 1ns / 1ps

// Roman numeral decoder. Each input word carries one 16-bit character code
// and the position of the string's first character; the numeral at the head
// of each zero-terminated string is decoded without regard to case and one
// output word (total modulo 65536, position of the last Roman digit) is
// produced at the first non-Roman character or the terminator. Characters
// after that, up to and including the terminator, produce nothing. The block
// sustains one character per cycle while the output is not stalled: a word
// is registered in the input register, the digit lookup and the single add
// or subtract of the held digit are combinational, and a result is
// registered in the output register when its character moves on from the
// input register. A stalled output holds the pipeline, with one more
// character buffered in the input register.
module roman_numeral_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] code, [31:16] start_offset
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] total, [31:16] end_position
);

    logic             stage_valid;
    logic             advance;
    logic             fire;
    rnd_pkg::item_t   stage_item;
    rnd_pkg::item_t   in_item;
    logic             res_valid;
    rnd_pkg::result_t res;

    logic             out_valid_reg;
    logic             out_valid_next;
    rnd_pkg::result_t out_data_reg;

    assign in_item.code         = s_tdata[15:0];
    assign in_item.start_offset = s_tdata[31:16];

    // Move the buffered character on whenever the output slot is free or drains
    assign advance = !out_valid_reg || m_tready;
    assign fire    = stage_valid && advance;

    rnd_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (stage_valid),
        .out_take  (advance),
        .out_item  (stage_item)
    );

    rnd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (stage_item),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: load a new result, drop the old one once taken
    always_comb
    begin
        if (fire && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.end_position, out_data_reg.total};

endmodule

// ===== sv/rnd_checker.sv =====
`timescale 1ns / 1ps

module rnd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // A draining output never blocks the input side
    a_ready_when_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // An empty output slot never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

    // Output cannot appear without an input word seen before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output word appeared without an input word");

endmodule

bind roman_numeral_decoder rnd_checker u_rnd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/numeral_check_pkg.sv =====
`timescale 1ns / 1ps

package numeral_check_pkg;

    import rnd_pkg::*;

    localparam logic [CODE_W-1:0] LOWER_A  = 16'h0061;
    localparam logic [CODE_W-1:0] LOWER_Z  = 16'h007A;
    localparam logic [CODE_W-1:0] CASE_GAP = 16'h0020;
    localparam int                MAX_SHOWN = 40;

    // Worth of one character: fold lower case onto upper, then look it up
    function automatic logic [DIGIT_W-1:0] digit_worth(input logic [CODE_W-1:0] ch);
        logic [CODE_W-1:0] folded;
        folded = ch;
        if (ch >= LOWER_A && ch <= LOWER_Z)
        begin
            folded = ch - CASE_GAP;
        end
        unique case (folded)
            CH_I_UP: return VAL_I;
            CH_V_UP: return VAL_V;
            CH_X_UP: return VAL_X;
            CH_L_UP: return VAL_L;
            CH_C_UP: return VAL_C;
            CH_D_UP: return VAL_D;
            CH_M_UP: return VAL_M;
            default: return VAL_NONE;
        endcase
    endfunction

    class numeral_scoreboard;

        result_t             expected_q[$];
        int unsigned         mismatches;

        logic [DIGIT_W-1:0]  held;
        logic [TOTAL_W-1:0]  sum;
        logic [POS_W-1:0]    digits;
        logic [POS_W-1:0]    base;
        bit                  open_string;
        bit                  skip_to_term;

        function new();
            mismatches   = 0;
            held         = VAL_NONE;
            sum          = '0;
            digits       = '0;
            base         = '0;
            open_string  = 1'b0;
            skip_to_term = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the numeral state by one accepted character
        function void note_char(input item_t w);
            logic [DIGIT_W-1:0] v;
            result_t            r;
            if (skip_to_term)
            begin
                if (w.code == CH_TERM)
                begin
                    skip_to_term = 1'b0;
                    open_string  = 1'b0;
                end
                return;
            end
            if (!open_string)
            begin
                open_string = 1'b1;
                base        = w.start_offset;
                sum         = '0;
                digits      = '0;
                held        = VAL_NONE;
            end
            v = digit_worth(w.code);
            if (held != VAL_NONE)
            begin
                if (held >= v)
                    sum = sum + held;
                else
                    sum = sum - held;
            end
            if (v != VAL_NONE)
            begin
                held   = v;
                digits = digits + 1'b1;
                return;
            end
            r.total        = sum;
            r.end_position = base + digits - 1'b1;
            expected_q.push_back(r);
            held = VAL_NONE;
            if (w.code == CH_TERM)
                open_string = 1'b0;
            else
                skip_to_term = 1'b1;
        endfunction

        task flag_mismatch(input string msg);
            if (mismatches < MAX_SHOWN)
                $display("%0t ns  mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(input result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word total=%0d end_position=%0d",
                                        got.total, got.end_position));
                return;
            end
            want = expected_q.pop_front();
            if (got.total !== want.total)
                flag_mismatch($sformatf("total %0d, want %0d", got.total, want.total));
            if (got.end_position !== want.end_position)
                flag_mismatch($sformatf("end_position %0d, want %0d",
                                        got.end_position, want.end_position));
        endtask

    endclass

endpackage

// ===== tb/sv/roman_numeral_decoder_test.sv =====
`timescale 1ns / 1ps

module roman_numeral_decoder_test;

    import rnd_pkg::*;
    import numeral_check_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int TAIL_CYCLES   = 8;     // wait before the verdict for any stray extra result word
    localparam int PHASE_CHARS   = 325;
    localparam int NUM_PHASES    = 4;

    // Idle percentages per phase: quiet, sender gaps, receiver stalls, both
    localparam int SEND_IDLE [NUM_PHASES] = '{0, 64, 0, 24};
    localparam int RECV_IDLE [NUM_PHASES] = '{0, 0, 64, 24};

    localparam logic [CODE_W-1:0] ROMAN_SET [14] = '{
        CH_I_UP, CH_V_UP, CH_X_UP, CH_L_UP, CH_C_UP, CH_D_UP, CH_M_UP,
        CH_I_LO, CH_V_LO, CH_X_LO, CH_L_LO, CH_C_LO, CH_D_LO, CH_M_LO
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [15:0] code, [31:16] start_offset
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [15:0] total, [31:16] end_position

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          chars_sent    = 0;
    int          quiet_cycles  = 0;

    numeral_scoreboard sb = new();

    always #1 clk = ~clk;

    roman_numeral_decoder i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Receiver: drop tready at random, at the rate of the current phase
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every output word that moves against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: abort when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved in %0d cycles, %0d results outstanding",
                     STALL_LIMIT, sb.pending());
            $display("roman_numeral_decoder_test: done, errors");
            $finish;
        end
    end

    // Push one character word; hold tvalid through any back-pressure.
    // Gaps go in front of the word so tvalid is never dropped and raised
    // again within the same step.
    task automatic send_char(input logic [CODE_W-1:0] ch, input logic [POS_W-1:0] start);
        item_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        w.code         = ch;
        w.start_offset = start;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_char(w);
        chars_sent++;
    endtask

    // Send an ASCII string as character words; start_offset is random on
    // every word after the first, since only the first one is sampled
    task automatic send_text(input string txt, input logic [POS_W-1:0] start);
        for (int i = 0; i < txt.len(); i++)
            send_char({8'h00, txt[i]}, (i == 0) ? start : POS_W'($urandom));
    endtask

    function automatic logic [CODE_W-1:0] pick_digit();
        return ROMAN_SET[$urandom_range(13)];
    endfunction

    // Any nonzero code that is not a Roman digit
    function automatic logic [CODE_W-1:0] pick_stopper();
        logic [CODE_W-1:0] c;
        do
            c = CODE_W'($urandom_range(65535, 1));
        while (digit_worth(c) != VAL_NONE);
        return c;
    endfunction

    // One random string: mostly a numeral with random content, closed by the
    // terminator or by a stray character and some junk; now and then a long
    // run of M to wrap the total, or a string of raw codes as noise
    task automatic send_random_string();
        int                 n;
        int                 shape;
        logic [CODE_W-1:0]  c;
        shape = $urandom_range(19);
        if (shape == 0)
        begin
            n = $urandom_range(80, 66);
            for (int i = 0; i < n; i++)
                send_char(($urandom_range(1) != 0) ? CH_M_UP : CH_M_LO, POS_W'($urandom));
        end
        else if (shape == 1)
        begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
            begin
                c = CODE_W'($urandom);
                send_char((c == CH_TERM) ? CODE_W'(1) : c, POS_W'($urandom));
            end
        end
        else
        begin
            n = $urandom_range(12);
            for (int i = 0; i < n; i++)
                send_char(pick_digit(), POS_W'($urandom));
        end

        if ($urandom_range(1) != 0)
        begin
            // junk after the stopper may hold Roman digits; all of it is skipped
            send_char(pick_stopper(), POS_W'($urandom));
            n = $urandom_range(4);
            for (int i = 0; i < n; i++)
                send_char(($urandom_range(1) != 0) ? pick_digit() : pick_stopper(),
                          POS_W'($urandom));
        end
        send_char(CH_TERM, POS_W'($urandom));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty string: terminator first, end position wraps below zero
        send_char(CH_TERM, 16'h0000);
        // Mixed case, subtractive pairs, end position wraps past the top
        send_text("mCmXcIv", 16'hFFFF);
        send_char(CH_TERM, 16'h0000);
        // Stray character ends the numeral; skip all-ones, a digit, then terminate
        send_text("Dl?", 16'h8000);
        send_char(16'hFFFF, 16'hFFFF);
        send_char(CH_X_UP, 16'h0000);
        send_char(CH_TERM, 16'hFFFF);
        // Non-Roman first character
        send_char(16'h8000, 16'h1234);
        send_char(CH_TERM, 16'h0000);
        // Repeated digit straight into the terminator
        send_text("ii", 16'h5555);
        send_char(CH_TERM, 16'hAAAA);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = SEND_IDLE[p];
            recv_idle_pct = RECV_IDLE[p];
            chars_sent    = 0;
            while (chars_sent < PHASE_CHARS)
                send_random_string();
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // Let any stray extra word show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("roman_numeral_decoder_test: done, clean");
        else
            $display("roman_numeral_decoder_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rnd_pkg.sv
sv/rnd_in_reg.sv
sv/rnd_core.sv
sv/roman_numeral_decoder.sv
sv/rnd_checker.sv
tb/sv/numeral_check_pkg.sv
tb/sv/roman_numeral_decoder_test.sv
